// ===== hdl/blob_tracker_vehicle_counter_macros.svh =====
// Assertion macros shared by the blob tracker and vehicle counter RTL.
`ifndef BLOB_TRACKER_VEHICLE_COUNTER_MACROS_SVH
`define BLOB_TRACKER_VEHICLE_COUNTER_MACROS_SVH

// Same-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define BTVC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define BTVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/btvc_pkg.sv =====
// Types and constants shared by the blob tracker and vehicle counter modules.
package btvc_pkg;

  typedef enum logic [1:0] {
    OP_BLOB  = 2'd0,
    OP_PURGE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_MATCHED = 3'd0,
    ST_NEW     = 3'd1,
    ST_SMALL   = 3'd2,
    ST_FULL    = 3'd3,
    ST_PURGED  = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_BIKE  = 2'd1,
    CLS_CAR   = 2'd2,
    CLS_TRUCK = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_EDGE_MARGIN  = 3'd1,
    CFG_MIN_AREA     = 3'd2,
    CFG_CAR_AREA     = 3'd3,
    CFG_TRUCK_AREA   = 3'd4,
    CFG_MATCH_DIST   = 3'd5,
    CFG_STALE_AGE    = 3'd6
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_READ,
    S_DIST_X,
    S_DIST_Y,
    S_COMMIT,
    S_DONE
  } state_e;

  localparam int unsigned CoordW = 12;
  localparam int unsigned AreaW  = 22;
  localparam int unsigned FrameW = 24;
  localparam int unsigned IdW    = 32;
  localparam int unsigned CfgW   = 22;
  localparam int unsigned OutCntW = 16;

  typedef struct packed {
    logic [CoordW-1:0] centre_x;
    logic [CoordW-1:0] centre_y;
    logic [CoordW-1:0] previous_x;
    logic [FrameW-1:0] last_seen;
    cls_e              track_class;
    logic [IdW-1:0]    creation;
  } slot_t;

  typedef struct packed {
    op_e  op;
    logic too_small;
    logic purge_mode;
    logic skip;
  } stat_t;

  typedef struct packed {
    state_e state;
    logic   last;
  } ctl_t;

endpackage

// ===== hdl/btvc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module btvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/btvc_counters.sv =====
// Six saturating vehicle counters, indexed by class and direction.
module btvc_counters #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  inc_i,
  input  logic [2:0]            sel_i,
  output logic [COUNT_BITS-1:0] cnt_o [6]
);

  logic [COUNT_BITS-1:0] cnt_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (clr_i) begin
      for (int k = 0; k < 6; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (inc_i) begin
      for (int k = 0; k < 6; k++) begin
        if (sel_i == 3'(k) && cnt_q[k] != '1) begin
          cnt_q[k] <= cnt_q[k] + 1'b1;
        end
      end
    end
  end

  assign cnt_o = cnt_q;

endmodule

// ===== hdl/btvc_ctrl.sv =====
// Sequencer that steps the shared distance unit over the track slots.
module btvc_ctrl #(
  parameter int unsigned TRACK_SLOTS = 16,
  localparam int unsigned SlotW = $clog2(TRACK_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  btvc_pkg::stat_t   stat_i,
  output logic              busy_o,
  output btvc_pkg::ctl_t    ctl_o,
  output logic [SlotW-1:0]  idx_o
);

  btvc_pkg::state_e state_q, state_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic             last;

  assign last = (idx_q == SlotW'(TRACK_SLOTS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btvc_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (stat_i.op)
            btvc_pkg::OP_BLOB: begin
              state_d = stat_i.too_small ? btvc_pkg::S_DONE : btvc_pkg::S_LIMIT;
            end
            btvc_pkg::OP_PURGE: state_d = btvc_pkg::S_READ;
            btvc_pkg::OP_CLEAR: state_d = btvc_pkg::S_DONE;
            btvc_pkg::OP_NONE:  state_d = btvc_pkg::S_IDLE;
          endcase
        end
      end
      btvc_pkg::S_LIMIT: state_d = btvc_pkg::S_READ;
      btvc_pkg::S_READ:  state_d = btvc_pkg::S_DIST_X;
      btvc_pkg::S_DIST_X: begin
        if (stat_i.purge_mode || stat_i.skip) begin
          if (!last) begin
            state_d = btvc_pkg::S_READ;
          end else if (stat_i.purge_mode) begin
            state_d = btvc_pkg::S_DONE;
          end else begin
            state_d = btvc_pkg::S_COMMIT;
          end
        end else begin
          state_d = btvc_pkg::S_DIST_Y;
        end
      end
      btvc_pkg::S_DIST_Y: state_d = last ? btvc_pkg::S_COMMIT : btvc_pkg::S_READ;
      btvc_pkg::S_COMMIT: state_d = btvc_pkg::S_DONE;
      btvc_pkg::S_DONE:   state_d = btvc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (state_q == btvc_pkg::S_IDLE) begin
      idx_d = '0;
    end else if ((state_q == btvc_pkg::S_DIST_X || state_q == btvc_pkg::S_DIST_Y) &&
                 state_d == btvc_pkg::S_READ) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_comb begin
    busy_o      = (state_q != btvc_pkg::S_IDLE);
    ctl_o.state = state_q;
    ctl_o.last  = last;
    idx_o       = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btvc_pkg::S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== hdl/blob_tracker_vehicle_counter.sv =====
// Top level of the blob tracker and vehicle counter with its slot-scan datapath.
// A blob request squares the match distance, then reads each slot and squares dx and, for a
// live slot only, dy, then commits; the single 12x12 squaring unit serves every slot. Purge
// reads and checks each slot in turn, and a small blob or a clear goes straight to the result
// strobe. A new request is taken the cycle after the strobe.
// Reset clears the slot valid bits, counters and track number and reloads the register defaults.
`include "blob_tracker_vehicle_counter_macros.svh"

module blob_tracker_vehicle_counter #(
  parameter int unsigned TRACK_SLOTS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] box_x_i,
  input  logic [11:0] box_y_i,
  input  logic [11:0] box_width_i,
  input  logic [11:0] box_height_i,
  input  logic [21:0] blob_area_i,
  input  logic [23:0] frame_number_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] track_id_o,
  output logic [1:0]  vehicle_class_o,
  output logic        heading_right_o,
  output logic        counted_now_o,
  output logic [15:0] bikes_left_o,
  output logic [15:0] bikes_right_o,
  output logic [15:0] cars_left_o,
  output logic [15:0] cars_right_o,
  output logic [15:0] trucks_left_o,
  output logic [15:0] trucks_right_o
);

  localparam int unsigned SlotW = $clog2(TRACK_SLOTS);
  localparam int unsigned SlotBits = $bits(btvc_pkg::slot_t);

  // Configuration registers.
  logic [11:0] frame_width_q;
  logic [10:0] edge_margin_q;
  logic [21:0] min_area_q, car_area_q, truck_area_q;
  logic [11:0] match_dist_q;
  logic [7:0]  stale_age_q;

  // Request registers.
  btvc_pkg::op_e op_q;
  logic [11:0] cx_q, cy_q;
  logic [21:0] area_q;
  logic [23:0] frame_q;

  // Scan state.
  logic [TRACK_SLOTS-1:0] valid_q;
  logic [31:0] next_num_q;
  logic [23:0] limit_q, dsq_q;
  logic        found_q, free_found_q;
  logic [SlotW-1:0] best_idx_q, free_idx_q;
  logic [31:0] best_age_q, best_id_q;
  logic [11:0] best_cx_q;
  btvc_pkg::cls_e best_cls_q;

  // Result registers.
  btvc_pkg::status_e res_status_q;
  logic [31:0] res_id_q;
  btvc_pkg::cls_e res_cls_q;
  logic        res_right_q, res_counted_q;

  btvc_pkg::ctl_t  ctl;
  btvc_pkg::stat_t stat;
  logic [SlotW-1:0] idx;
  logic        accept;

  logic [12:0] cx_sum, cy_sum;
  logic [11:0] cx_in, cy_in;

  logic [SlotBits-1:0] ram_rdata;
  btvc_pkg::slot_t     rd_slot, wr_slot;
  logic        ram_we;
  logic [SlotW-1:0] target;

  logic [11:0] mul_a, dx, dy;
  logic [23:0] prod;
  logic [23:0] age;
  logic        stale;
  logic [24:0] dist_sum;
  logic [31:0] cand_age;
  logic        better;

  logic [11:0] prev_x;
  btvc_pkg::cls_e cls_old, cls_area, cls_new;
  logic        right, in_margin, do_count, have_slot;
  logic signed [13:0] right_edge, cx_s;

  logic [COUNT_BITS-1:0] cnt [6];

  assign accept = start && !busy;

  assign cx_sum = {1'b0, box_x_i} + {2'b0, box_width_i[11:1]};
  assign cy_sum = {1'b0, box_y_i} + {2'b0, box_height_i[11:1]};
  assign cx_in  = cx_sum[12] ? 12'hFFF : cx_sum[11:0];
  assign cy_in  = cy_sum[12] ? 12'hFFF : cy_sum[11:0];

  assign stat.op         = btvc_pkg::op_e'(opcode_i);
  assign stat.too_small  = (blob_area_i <= min_area_q);
  assign stat.purge_mode = (op_q == btvc_pkg::OP_PURGE);
  assign stat.skip       = !valid_q[idx] || stale;

  btvc_ctrl #(
    .TRACK_SLOTS(TRACK_SLOTS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .busy_o (busy),
    .ctl_o  (ctl),
    .idx_o  (idx)
  );

  btvc_ram #(
    .WIDTH(SlotBits),
    .DEPTH(TRACK_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(target),
    .wdata_i(wr_slot),
    .re_i   (ctl.state == btvc_pkg::S_READ),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  assign rd_slot = btvc_pkg::slot_t'(ram_rdata);

  // Shared squaring unit and slot checks.
  assign dx = (cx_q > rd_slot.centre_x) ? cx_q - rd_slot.centre_x : rd_slot.centre_x - cx_q;
  assign dy = (cy_q > rd_slot.centre_y) ? cy_q - rd_slot.centre_y : rd_slot.centre_y - cy_q;

  always_comb begin
    if (ctl.state == btvc_pkg::S_LIMIT) begin
      mul_a = match_dist_q;
    end else if (ctl.state == btvc_pkg::S_DIST_Y) begin
      mul_a = dy;
    end else begin
      mul_a = dx;
    end
  end

  assign prod     = {12'b0, mul_a} * {12'b0, mul_a};
  assign age      = frame_q - rd_slot.last_seen;
  assign stale    = (age >= {16'b0, stale_age_q});
  assign dist_sum = {1'b0, dsq_q} + {1'b0, prod};
  assign cand_age = next_num_q - rd_slot.creation;
  assign better   = (dist_sum < {1'b0, limit_q}) && (!found_q || cand_age > best_age_q);

  // Commit: update or allocate the track and classify it.
  always_comb begin
    have_slot = found_q || free_found_q;
    if (found_q) begin
      target  = best_idx_q;
      prev_x  = best_cx_q;
      cls_old = best_cls_q;
    end else begin
      target  = free_idx_q;
      prev_x  = cx_q;
      cls_old = btvc_pkg::CLS_NONE;
    end
    right      = (prev_x < cx_q);
    right_edge = $signed({2'b0, frame_width_q}) - $signed({3'b0, edge_margin_q});
    cx_s       = $signed({2'b0, cx_q});
    in_margin  = (cx_q > {1'b0, edge_margin_q}) && (cx_s < right_edge);
    if (area_q < car_area_q) begin
      cls_area = btvc_pkg::CLS_BIKE;
    end else if (area_q < truck_area_q) begin
      cls_area = btvc_pkg::CLS_CAR;
    end else begin
      cls_area = btvc_pkg::CLS_TRUCK;
    end
    do_count = (ctl.state == btvc_pkg::S_COMMIT) && have_slot &&
               (cls_old == btvc_pkg::CLS_NONE) && in_margin;
    cls_new  = do_count ? cls_area : cls_old;
    ram_we   = (ctl.state == btvc_pkg::S_COMMIT) && have_slot;
    wr_slot.centre_x    = cx_q;
    wr_slot.centre_y    = cy_q;
    wr_slot.previous_x  = prev_x;
    wr_slot.last_seen   = frame_q;
    wr_slot.track_class = cls_new;
    wr_slot.creation    = found_q ? best_id_q : next_num_q;
  end

  btvc_counters #(
    .COUNT_BITS(COUNT_BITS)
  ) u_counters (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .clr_i (accept && opcode_i == btvc_pkg::OP_CLEAR),
    .inc_i (do_count),
    .sel_i ({cls_new - 2'd1, right}),
    .cnt_o (cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= 12'd640;
      edge_margin_q <= 11'd200;
      min_area_q    <= 22'd8000;
      car_area_q    <= 22'd18000;
      truck_area_q  <= 22'd80000;
      match_dist_q  <= 12'd150;
      stale_age_q   <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (btvc_pkg::cfg_e'(cfg_idx_i))
        btvc_pkg::CFG_FRAME_WIDTH: frame_width_q <= cfg_wdata_i[11:0];
        btvc_pkg::CFG_EDGE_MARGIN: edge_margin_q <= cfg_wdata_i[10:0];
        btvc_pkg::CFG_MIN_AREA:    min_area_q    <= cfg_wdata_i;
        btvc_pkg::CFG_CAR_AREA:    car_area_q    <= cfg_wdata_i;
        btvc_pkg::CFG_TRUCK_AREA:  truck_area_q  <= cfg_wdata_i;
        btvc_pkg::CFG_MATCH_DIST:  match_dist_q  <= cfg_wdata_i[11:0];
        btvc_pkg::CFG_STALE_AGE:   stale_age_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      next_num_q   <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (accept) begin
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (ctl.state == btvc_pkg::S_DIST_X) begin
        if (op_q == btvc_pkg::OP_PURGE) begin
          if (valid_q[idx] && stale) begin
            valid_q[idx] <= 1'b0;
          end
        end else if (!valid_q[idx] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (ctl.state == btvc_pkg::S_DIST_Y && better) begin
        found_q <= 1'b1;
      end
      if (ctl.state == btvc_pkg::S_COMMIT && !found_q && free_found_q) begin
        valid_q[free_idx_q] <= 1'b1;
        next_num_q          <= next_num_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q          <= btvc_pkg::op_e'(opcode_i);
      cx_q          <= cx_in;
      cy_q          <= cy_in;
      area_q        <= blob_area_i;
      frame_q       <= frame_number_i;
      res_id_q      <= '0;
      res_cls_q     <= btvc_pkg::CLS_NONE;
      res_right_q   <= 1'b0;
      res_counted_q <= 1'b0;
      priority if (opcode_i == btvc_pkg::OP_PURGE) begin
        res_status_q <= btvc_pkg::ST_PURGED;
      end else if (opcode_i == btvc_pkg::OP_CLEAR) begin
        res_status_q <= btvc_pkg::ST_CLEARED;
      end else begin
        res_status_q <= btvc_pkg::ST_SMALL;
      end
    end
    if (ctl.state == btvc_pkg::S_LIMIT) begin
      limit_q <= prod;
    end
    if (ctl.state == btvc_pkg::S_DIST_X) begin
      dsq_q <= prod;
      if (op_q != btvc_pkg::OP_PURGE && !valid_q[idx] && !free_found_q) begin
        free_idx_q <= idx;
      end
    end
    if (ctl.state == btvc_pkg::S_DIST_Y && better) begin
      best_idx_q <= idx;
      best_age_q <= cand_age;
      best_cx_q  <= rd_slot.centre_x;
      best_cls_q <= rd_slot.track_class;
      best_id_q  <= rd_slot.creation;
    end
    if (ctl.state == btvc_pkg::S_COMMIT) begin
      if (have_slot) begin
        res_status_q  <= found_q ? btvc_pkg::ST_MATCHED : btvc_pkg::ST_NEW;
        res_id_q      <= wr_slot.creation;
        res_cls_q     <= cls_new;
        res_right_q   <= right;
        res_counted_q <= do_count;
      end else begin
        res_status_q  <= btvc_pkg::ST_FULL;
      end
    end
  end

  assign done_o          = (ctl.state == btvc_pkg::S_DONE);
  assign status_o        = res_status_q;
  assign track_id_o      = res_id_q;
  assign vehicle_class_o = res_cls_q;
  assign heading_right_o = res_right_q;
  assign counted_now_o   = res_counted_q;
  assign bikes_left_o    = 16'(cnt[0]);
  assign bikes_right_o   = 16'(cnt[1]);
  assign cars_left_o     = 16'(cnt[2]);
  assign cars_right_o    = 16'(cnt[3]);
  assign trucks_left_o   = 16'(cnt[4]);
  assign trucks_right_o  = 16'(cnt[5]);

  `BTVC_ASSERT_NEXT(a_busy_after_request, accept && opcode_i != btvc_pkg::OP_NONE, busy, "A request did not make the block busy.")
  `BTVC_ASSERT_NEXT(a_single_strobe, done_o, !done_o, "The result strobe lasted more than one cycle.")
  `BTVC_ASSERT_NEXT(a_track_number_hold, ctl.state != btvc_pkg::S_COMMIT, $stable(next_num_q), "The track number moved outside a commit.")
  `BTVC_ASSERT_IMPL(a_count_needs_track, done_o && counted_now_o, status_o == btvc_pkg::ST_MATCHED || status_o == btvc_pkg::ST_NEW, "A count was reported without a track.")

endmodule

// ===== sim/blob_tracker_vehicle_counter_checker.sv =====
// Checker that follows tracker requests and register writes, predicts each report and compares it.
module blob_tracker_vehicle_counter_checker
  import btvc_pkg::*;
#(
  parameter int unsigned TRACK_SLOTS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] box_x_i,
  input  logic [11:0] box_y_i,
  input  logic [11:0] box_width_i,
  input  logic [11:0] box_height_i,
  input  logic [21:0] blob_area_i,
  input  logic [23:0] frame_number_i,
  input  logic        done_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] track_id_i,
  input  logic [1:0]  vehicle_class_i,
  input  logic        heading_right_i,
  input  logic        counted_now_i,
  input  logic [15:0] bikes_left_i,
  input  logic [15:0] bikes_right_i,
  input  logic [15:0] cars_left_i,
  input  logic [15:0] cars_right_i,
  input  logic [15:0] trucks_left_i,
  input  logic [15:0] trucks_right_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    status_e          status;
    logic [31:0]      track_id;
    cls_e             vehicle_class;
    logic             heading_right;
    logic             counted_now;
    logic [5:0][15:0] counts;
  } report_t;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [11:0] frame_width;
  logic [10:0] edge_margin;
  logic [21:0] min_area;
  logic [21:0] car_area;
  logic [21:0] truck_area;
  logic [11:0] match_dist;
  logic [7:0]  stale_age;

  logic                  slot_valid   [TRACK_SLOTS];
  logic [11:0]           slot_cx      [TRACK_SLOTS];
  logic [11:0]           slot_cy      [TRACK_SLOTS];
  logic [11:0]           slot_px      [TRACK_SLOTS];
  logic [23:0]           slot_seen    [TRACK_SLOTS];
  cls_e                  slot_class   [TRACK_SLOTS];
  logic [31:0]           slot_created [TRACK_SLOTS];
  logic [31:0]           next_number;
  logic [COUNT_BITS-1:0] class_count  [6];

  report_t          expected_reports [$];
  report_t          oldest;
  logic [5:0][15:0] seen_counts;
  int               failures;

  assign seen_counts = {trucks_right_i, trucks_left_i, cars_right_i, cars_left_i,
                        bikes_right_i, bikes_left_i};

  function automatic logic [11:0] centre_of(logic [11:0] pos, logic [11:0] len);
    logic [12:0] sum;
    sum = {1'b0, pos} + {2'b00, len[11:1]};
    return sum[12] ? 12'hFFF : sum[11:0];
  endfunction

  function automatic report_t make_report(status_e st, logic [31:0] id, cls_e cls,
                                          logic right, logic counted);
    report_t r;
    int      k;
    r.status        = st;
    r.track_id      = id;
    r.vehicle_class = cls;
    r.heading_right = right;
    r.counted_now   = counted;
    for (k = 0; k < 6; k++) r.counts[k] = 16'(class_count[k]);
    return r;
  endfunction

  task automatic add_report(input report_t r);
    expected_reports = {expected_reports, r};
  endtask

  task automatic track_request(input op_e op, input logic [11:0] bx, input logic [11:0] by,
                               input logic [11:0] bw, input logic [11:0] bh,
                               input logic [21:0] area, input logic [23:0] frame);
    logic [11:0] cx, cy, dx, dy;
    logic [23:0] age;
    logic [25:0] dist2;
    logic [23:0] lim2;
    logic [31:0] cand_age, best_age;
    logic        right, counted;
    cls_e        cls;
    status_e     st;
    int          s, best, idx, hi;
    best     = -1;
    best_age = '0;
    counted  = 1'b0;
    case (op)
      OP_PURGE: begin
        for (s = 0; s < TRACK_SLOTS; s++) begin
          age = frame - slot_seen[s];
          if (slot_valid[s] && age >= {16'd0, stale_age}) slot_valid[s] = 1'b0;
        end
        add_report(make_report(ST_PURGED, '0, CLS_NONE, 1'b0, 1'b0));
      end
      OP_CLEAR: begin
        for (s = 0; s < 6; s++) class_count[s] = '0;
        add_report(make_report(ST_CLEARED, '0, CLS_NONE, 1'b0, 1'b0));
      end
      OP_BLOB: begin
        if (area <= min_area) begin
          add_report(make_report(ST_SMALL, '0, CLS_NONE, 1'b0, 1'b0));
          return;
        end
        cx   = centre_of(bx, bw);
        cy   = centre_of(by, bh);
        lim2 = match_dist * match_dist;
        for (s = 0; s < TRACK_SLOTS; s++) begin
          age = frame - slot_seen[s];
          if (slot_valid[s] && age < {16'd0, stale_age}) begin
            dx    = (cx > slot_cx[s]) ? cx - slot_cx[s] : slot_cx[s] - cx;
            dy    = (cy > slot_cy[s]) ? cy - slot_cy[s] : slot_cy[s] - cy;
            dist2 = dx * dx + dy * dy;
            if (dist2 < {2'b00, lim2}) begin
              cand_age = next_number - slot_created[s];
              if (best < 0 || cand_age > best_age) begin
                best     = s;
                best_age = cand_age;
              end
            end
          end
        end
        if (best >= 0) begin
          slot_px[best]   = slot_cx[best];
          slot_cx[best]   = cx;
          slot_cy[best]   = cy;
          slot_seen[best] = frame;
          st              = ST_MATCHED;
        end else begin
          for (s = 0; s < TRACK_SLOTS; s++) if (best < 0 && !slot_valid[s]) best = s;
          if (best < 0) begin
            add_report(make_report(ST_FULL, '0, CLS_NONE, 1'b0, 1'b0));
            return;
          end
          slot_valid[best]   = 1'b1;
          slot_cx[best]      = cx;
          slot_cy[best]      = cy;
          slot_px[best]      = cx;
          slot_seen[best]    = frame;
          slot_class[best]   = CLS_NONE;
          slot_created[best] = next_number;
          next_number        = next_number + 1;
          st                 = ST_NEW;
        end
        right = slot_px[best] < slot_cx[best];
        if (slot_class[best] == CLS_NONE) begin
          hi = int'(frame_width) - int'(edge_margin);
          if (cx > edge_margin && int'(cx) < hi) begin
            if (area < car_area) cls = CLS_BIKE;
            else if (area < truck_area) cls = CLS_CAR;
            else cls = CLS_TRUCK;
            idx = (int'(cls) - 1) * 2 + int'(right);
            slot_class[best] = cls;
            if (class_count[idx] < CountMax) class_count[idx] = class_count[idx] + 1'b1;
            counted = 1'b1;
          end
        end
        add_report(make_report(st, slot_created[best], slot_class[best], right, counted));
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin : clear_state
      int s;
      frame_width = 12'd640;
      edge_margin = 11'd200;
      min_area    = 22'd8000;
      car_area    = 22'd18000;
      truck_area  = 22'd80000;
      match_dist  = 12'd150;
      stale_age   = 8'd5;
      for (s = 0; s < TRACK_SLOTS; s++) begin
        slot_valid[s]   = 1'b0;
        slot_cx[s]      = '0;
        slot_cy[s]      = '0;
        slot_px[s]      = '0;
        slot_seen[s]    = '0;
        slot_class[s]   = CLS_NONE;
        slot_created[s] = '0;
      end
      for (s = 0; s < 6; s++) class_count[s] = '0;
      next_number = '0;
      expected_reports.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin : watch
      int k;
      if (done_i === 1'b1) begin
        if (expected_reports.size() == 0) begin
          failures++;
          $display("%0t: report with no request waiting, expected none actual status %0d",
                   $time, status_i);
        end else begin
          oldest = expected_reports.pop_front();
          check_field("status", 32'(oldest.status), 32'(status_i));
          check_field("track_id", oldest.track_id, track_id_i);
          check_field("vehicle_class", 32'(oldest.vehicle_class), 32'(vehicle_class_i));
          check_field("heading_right", 32'(oldest.heading_right), 32'(heading_right_i));
          check_field("counted_now", 32'(oldest.counted_now), 32'(counted_now_i));
          for (k = 0; k < 6; k++)
            check_field($sformatf("counter %0d", k), 32'(oldest.counts[k]),
                        32'(seen_counts[k]));
        end
      end
      if (cfg_we_i === 1'b1) begin
        case (cfg_e'(cfg_idx_i))
          CFG_FRAME_WIDTH: frame_width = cfg_wdata_i[11:0];
          CFG_EDGE_MARGIN: edge_margin = cfg_wdata_i[10:0];
          CFG_MIN_AREA:    min_area    = cfg_wdata_i;
          CFG_CAR_AREA:    car_area    = cfg_wdata_i;
          CFG_TRUCK_AREA:  truck_area  = cfg_wdata_i;
          CFG_MATCH_DIST:  match_dist  = cfg_wdata_i[11:0];
          CFG_STALE_AGE:   stale_age   = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        track_request(op_e'(opcode_i), box_x_i, box_y_i, box_width_i, box_height_i,
                      blob_area_i, frame_number_i);
      fail_count_o <= failures;
      pending_o    <= expected_reports.size();
    end
  end

endmodule

// ===== sim/blob_tracker_vehicle_counter_tb.sv =====
// Testbench top for the blob tracker and vehicle counter: stimulus, register setup and verdict.
module blob_tracker_vehicle_counter_tb;
  import btvc_pkg::*;

  localparam int CycleLimit   = 3_000_000;
  localparam int SettleCycles = 64;
  localparam int Phases       = 9;
  localparam int PhaseItems   = 150;
  localparam int Lanes        = 4;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_idx_i      = '0;
  logic [21:0] cfg_wdata_i    = '0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i       = '0;
  logic [11:0] box_x_i        = '0;
  logic [11:0] box_y_i        = '0;
  logic [11:0] box_width_i    = '0;
  logic [11:0] box_height_i   = '0;
  logic [21:0] blob_area_i    = '0;
  logic [23:0] frame_number_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] track_id_o;
  logic [1:0]  vehicle_class_o;
  logic        heading_right_o;
  logic        counted_now_o;
  logic [15:0] bikes_left_o, bikes_right_o, cars_left_o;
  logic [15:0] cars_right_o, trucks_left_o, trucks_right_o;

  int          fail_count;
  int          pending;
  int          cycles     = 0;
  int          requests   = 0;
  int          reg_writes = 0;
  int          idle_pct   = 0;
  int          fw_set     = 640;
  int          min_set    = 8000;
  int          truck_set  = 80000;
  logic [23:0] frame_now  = '0;
  int          lane_live [Lanes];
  int          lane_x    [Lanes];
  int          lane_y    [Lanes];
  int          lane_step [Lanes];
  longint      lane_area [Lanes];

  blob_tracker_vehicle_counter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .box_x_i        (box_x_i),
    .box_y_i        (box_y_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .blob_area_i    (blob_area_i),
    .frame_number_i (frame_number_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .track_id_o     (track_id_o),
    .vehicle_class_o(vehicle_class_o),
    .heading_right_o(heading_right_o),
    .counted_now_o  (counted_now_o),
    .bikes_left_o   (bikes_left_o),
    .bikes_right_o  (bikes_right_o),
    .cars_left_o    (cars_left_o),
    .cars_right_o   (cars_right_o),
    .trucks_left_o  (trucks_left_o),
    .trucks_right_o (trucks_right_o)
  );

  blob_tracker_vehicle_counter_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i       (opcode_i),
    .box_x_i        (box_x_i),
    .box_y_i        (box_y_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .blob_area_i    (blob_area_i),
    .frame_number_i (frame_number_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .track_id_i     (track_id_o),
    .vehicle_class_i(vehicle_class_o),
    .heading_right_i(heading_right_o),
    .counted_now_i  (counted_now_o),
    .bikes_left_i   (bikes_left_o),
    .bikes_right_i  (bikes_right_o),
    .cars_left_i    (cars_left_o),
    .cars_right_i   (cars_right_o),
    .trucks_left_i  (trucks_left_o),
    .trucks_right_i (trucks_right_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("blob_tracker_vehicle_counter verification failed");
      $finish;
    end
  end

  task automatic send_request(input op_e op, input logic [11:0] bx, input logic [11:0] by,
                              input logic [11:0] bw, input logic [11:0] bh,
                              input logic [21:0] area, input logic [23:0] frm);
    @(negedge clk_i);
    start          <= 1'b1;
    opcode_i       <= op;
    box_x_i        <= bx;
    box_y_i        <= by;
    box_width_i    <= bw;
    box_height_i   <= bh;
    blob_area_i    <= area;
    frame_number_i <= frm;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if (op != OP_NONE) requests++;
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start          <= 1'b0;
      opcode_i       <= 2'($urandom);
      box_x_i        <= 12'($urandom);
      box_y_i        <= 12'($urandom);
      box_width_i    <= 12'($urandom);
      box_height_i   <= 12'($urandom);
      blob_area_i    <= 22'($urandom);
      frame_number_i <= 24'($urandom);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= 22'(val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_FRAME_WIDTH: fw_set    = val;
      CFG_MIN_AREA:    min_set   = val;
      CFG_TRUCK_AREA:  truck_set = val;
      default: ;
    endcase
  endtask

  task automatic configure(input int fw, input int em, input int mn, input int car,
                           input int trk, input int md, input int st);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_EDGE_MARGIN, em);
    write_reg(CFG_MIN_AREA, mn);
    write_reg(CFG_CAR_AREA, car);
    write_reg(CFG_TRUCK_AREA, trk);
    write_reg(CFG_MATCH_DIST, md);
    write_reg(CFG_STALE_AGE, st);
  endtask

  task automatic vehicle_request();
    int     v, w, h, bx, by, span;
    longint area;
    span = (fw_set >= 100) ? fw_set : 640;
    v    = $urandom_range(Lanes - 1);
    if (!lane_live[v] || $urandom_range(99) < 3) begin
      lane_live[v] = 1;
      lane_y[v]    = $urandom_range(600);
      lane_area[v] = longint'(min_set) + 1 + $urandom_range(truck_set + 40000);
      if ($urandom_range(1)) begin
        lane_x[v]    = $urandom_range(span / 8);
        lane_step[v] = $urandom_range(4, 60);
      end else begin
        lane_x[v]    = span - int'($urandom_range(span / 8));
        lane_step[v] = -int'($urandom_range(4, 60));
      end
    end else begin
      lane_x[v] = lane_x[v] + lane_step[v];
      lane_y[v] = lane_y[v] + int'($urandom_range(10)) - 5;
      if (lane_y[v] < 0) lane_y[v] = 0;
      if (lane_x[v] < 0 || lane_x[v] > span) lane_live[v] = 0;
    end
    if ($urandom_range(99) < 35) frame_now = frame_now + 24'd1;
    else if ($urandom_range(99) < 2) frame_now = frame_now + 24'($urandom_range(3, 40));
    w  = $urandom_range(4, 300);
    h  = $urandom_range(4, 200);
    bx = lane_x[v] - w / 2;
    by = lane_y[v] - h / 2;
    if (bx < 0) bx = 0;
    if (bx > 4095) bx = 4095;
    if (by < 0) by = 0;
    if (by > 4095) by = 4095;
    area = lane_area[v] + $urandom_range(500);
    if (area > 4194303) area = 4194303;
    send_request(OP_BLOB, 12'(bx), 12'(by), 12'(w), 12'(h), 22'(area), frame_now);
  endtask

  task automatic random_request();
    int          pick;
    logic [21:0] area;
    logic [23:0] frm;
    pick = $urandom_range(99);
    frm  = ($urandom_range(99) < 70) ? frame_now : 24'($urandom);
    if ($urandom_range(999) < 5) frame_now = 24'($urandom);
    if (pick < 58) begin
      vehicle_request();
    end else if (pick < 72) begin
      area = $urandom_range(1) ? 22'($urandom) : 22'(min_set + 1 + $urandom_range(100000));
      send_request(OP_BLOB, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   area, frm);
    end else if (pick < 80) begin
      send_request(OP_BLOB, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   22'($urandom_range(min_set)), frm);
    end else if (pick < 88) begin
      send_request(OP_PURGE, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   22'($urandom), frame_now);
    end else if (pick < 92) begin
      send_request(OP_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   22'($urandom), 24'($urandom));
    end else if (pick < 95) begin
      send_request(OP_NONE, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   22'($urandom), 24'($urandom));
    end else begin
      send_request(op_e'($urandom_range(3)), 12'($urandom), 12'($urandom), 12'($urandom),
                   12'($urandom), 22'($urandom), 24'($urandom));
    end
    idle_gap();
  endtask

  initial begin
    int gx, gy, phase, goal, fw, em, mn, car, trk, md, st;
    for (gx = 0; gx < Lanes; gx++) lane_live[gx] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(OP_NONE, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                 22'($urandom), 24'($urandom));
    send_request(OP_BLOB, 250, 200, 100, 100, 8000, 10);
    send_request(OP_BLOB, 250, 200, 100, 100, 20000, 10);
    send_request(OP_BLOB, 270, 200, 100, 100, 20000, 11);
    send_request(OP_BLOB, 50, 600, 100, 100, 90000, 11);
    send_request(OP_BLOB, 200, 600, 100, 100, 90000, 12);
    send_request(OP_BLOB, 4095, 4095, 4095, 4095, 4194303, 12);
    send_request(OP_BLOB, 420, 200, 100, 100, 30000, 12);
    send_request(OP_BLOB, 345, 200, 100, 100, 30000, 13);
    send_request(OP_BLOB, 270, 200, 100, 100, 30000, 18);
    send_request(OP_PURGE, 0, 0, 0, 0, 0, 18);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0, 18);
    for (gy = 0; gy < 4; gy++)
      for (gx = 0; gx < 4; gx++)
        send_request(OP_BLOB, 12'(gx * 1365), 12'(gy * 1365), 0, 0, 30000, 18);

    for (phase = 0; phase < Phases; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 88;
        default: idle_pct = 12;
      endcase
      settle();
      case (phase)
        0: ;
        1: configure(4095, 0, 0, 4194303, 4194303, 4095, 255);
        2: configure(0, 2047, 4194303, 0, 0, 0, 1);
        3: configure(640, 200, 8000, 18000, 80000, 150, 5);
        default: begin
          fw  = ($urandom_range(99) < 70) ? $urandom_range(320, 1920) : $urandom_range(4095);
          em  = $urandom_range((fw / 3 > 2047) ? 2047 : fw / 3);
          mn  = $urandom_range(20000);
          car = mn + $urandom_range(30000);
          trk = car + $urandom_range(100000);
          md  = ($urandom_range(99) < 80) ? $urandom_range(20, 300) : $urandom_range(4095);
          st  = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(1, 255);
          configure(fw, em, mn, car, trk, md, st);
        end
      endcase
      if ($urandom_range(1)) frame_now = 24'hFFFFFF - 24'($urandom_range(300));
      else frame_now = 24'($urandom);
      goal = requests + ((phase == 2) ? PhaseItems / 4 : PhaseItems);
      while (requests < goal) random_request();
    end

    settle();
    $display("Summary: %0d requests checked over %0d register settings (%0d writes),",
             requests, Phases, reg_writes);
    $display("covering both register extremes and sender gaps of none, 12 and 88 percent.");
    if (fail_count == 0 && pending == 0) begin
      $display("blob_tracker_vehicle_counter verification clean");
    end else begin
      $display("blob_tracker_vehicle_counter verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/btvc_pkg.sv
hdl/btvc_ram.sv
hdl/btvc_counters.sv
hdl/btvc_ctrl.sv
hdl/blob_tracker_vehicle_counter.sv
sim/blob_tracker_vehicle_counter_checker.sv
sim/blob_tracker_vehicle_counter_tb.sv
